### src/gtbp_pkg.sv
// Shared types, register codes and counter helper for the branch predictor.
package gtbp_pkg;

  typedef enum logic [1:0] {
    MODE_STATIC_TAKEN = 2'd0,
    MODE_GSHARE       = 2'd1,
    MODE_TOURNAMENT   = 2'd2,
    MODE_NOT_TAKEN    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE        = 2'd0,
    REG_GLOBAL_BITS = 2'd1,
    REG_LOCAL_BITS  = 2'd2,
    REG_PC_BITS     = 2'd3
  } cfg_reg_t;

  localparam logic [3:0] GLOBAL_BITS_RESET = 4'd13;
  localparam logic [3:0] LOCAL_BITS_RESET  = 4'd11;
  localparam logic [3:0] PC_BITS_RESET     = 4'd10;

  // counter reset value: weakly not taken / weakly global
  localparam logic [1:0] CTR_WEAK_LOW = 2'd1;

  // depth of the result queue
  localparam int OUT_DEPTH = 4;

  // 2-bit saturating counter step
  function automatic logic [1:0] ctr_step(input logic [1:0] c, input logic taken);
    logic [1:0] r;
    if (taken) begin
      r = (c == 2'd3) ? 2'd3 : c + 2'd1;
    end else begin
      r = (c == 2'd0) ? 2'd0 : c - 2'd1;
    end
    return r;
  endfunction

endpackage

### src/gshare_tournament_branch_predictor.sv
// Gshare / tournament branch predictor: lookup, training and result queue.
//
//  channel  | direction | transaction carries
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | one resolved branch: pc, outcome
//  m_axis   | out       | predicted_taken for that branch, before training
//  cfg      | in        | one register write: index, data
//
// Throughput is one transaction per cycle while s_axis_tready is high. Each
// result passes table read, local counter read, then predict/train into the
// queue before it is offered on m_axis. After reset all tables are cleared in
// a single pass over the widest table index; s_axis_tready stays low meanwhile.
// Results wait in a four-entry queue; s_axis_tready drops once four branches
// are held between pipeline and queue, so m_axis stalls never lose data.
module gshare_tournament_branch_predictor #(
  parameter int MAX_GLOBAL_BITS = 13,
  parameter int MAX_LOCAL_BITS  = 11,
  parameter int MAX_PC_BITS     = 10
) (
  input  logic        clk,
  input  logic        rst,
  // s_axis_tdata, low bit up: pc[31:0], outcome[32], zero pad [39:33]
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // m_axis_tdata, low bit up: predicted_taken[0], zero pad [7:1]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int G = MAX_GLOBAL_BITS;
  localparam int L = MAX_LOCAL_BITS;
  localparam int P = MAX_PC_BITS;
  localparam int GL_W  = (G > L) ? G : L;
  localparam int CLR_W = (GL_W > P) ? GL_W : P;
  localparam int GDEPTH = 1 << G;
  localparam int LDEPTH = 1 << L;
  localparam int PDEPTH = 1 << P;
  localparam int OUT_AW = $clog2(gtbp_pkg::OUT_DEPTH);

  // ---------------- configuration registers ----------------
  gtbp_pkg::mode_t predictor_mode;
  logic [3:0]      global_history_bits;
  logic [3:0]      local_history_bits;
  logic [3:0]      pc_index_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      predictor_mode      <= gtbp_pkg::MODE_STATIC_TAKEN;
      global_history_bits <= gtbp_pkg::GLOBAL_BITS_RESET;
      local_history_bits  <= gtbp_pkg::LOCAL_BITS_RESET;
      pc_index_bits       <= gtbp_pkg::PC_BITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gtbp_pkg::cfg_reg_t'(cfg_index))
        gtbp_pkg::REG_MODE:        predictor_mode <= gtbp_pkg::mode_t'(cfg_data[1:0]);
        gtbp_pkg::REG_GLOBAL_BITS: global_history_bits <= cfg_data;
        gtbp_pkg::REG_LOCAL_BITS:  local_history_bits <= cfg_data;
        gtbp_pkg::REG_PC_BITS:     pc_index_bits <= cfg_data;
      endcase
    end
  end

  // Index masks: zero length acts as one, overlong is capped by the width.
  logic [G-1:0] gmask;
  logic [L-1:0] lmask;
  logic [P-1:0] pmask;

  always_comb begin
    for (int i = 0; i < G; i++) gmask[i] = (i == 0) || (i < int'(global_history_bits));
    for (int i = 0; i < L; i++) lmask[i] = (i == 0) || (i < int'(local_history_bits));
    for (int i = 0; i < P; i++) pmask[i] = (i == 0) || (i < int'(pc_index_bits));
  end

  logic trains;
  logic is_tour;
  assign is_tour = (predictor_mode == gtbp_pkg::MODE_TOURNAMENT);
  assign trains  = (predictor_mode == gtbp_pkg::MODE_GSHARE) || is_tour;

  // ---------------- clearing pass ----------------
  logic [CLR_W-1:0] clr_addr;
  logic             clear_done;
  logic             clearing;

  assign clearing = !clear_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      clear_done <= 1'b0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) clear_done <= 1'b1;
    end
  end

  logic clr_hit_g, clr_hit_l, clr_hit_p;
  assign clr_hit_g = clearing && ((clr_addr >> G) == '0);
  assign clr_hit_l = clearing && ((clr_addr >> L) == '0);
  assign clr_hit_p = clearing && ((clr_addr >> P) == '0);

  // ---------------- input side ----------------
  logic [31:0] in_pc;
  logic        in_taken;
  logic        in_accept;
  logic [G-1:0] global_history;
  logic [G:0]   ghist_shift;
  logic [G-1:0] in_gi;
  logic [P-1:0] in_pi;

  assign in_pc     = s_axis_tdata[31:0];
  assign in_taken  = s_axis_tdata[32];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign ghist_shift = {global_history, in_taken};
  assign in_pi = in_pc[P-1:0] & pmask;

  always_comb begin
    if (predictor_mode == gtbp_pkg::MODE_GSHARE) begin
      in_gi = (in_pc[G-1:0] ^ global_history) & gmask;
    end else begin
      in_gi = global_history & gmask;
    end
  end

  // outcome is known on entry, so the global history moves at acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      global_history <= '0;
    end else if (in_accept && trains) begin
      global_history <= ghist_shift[G-1:0];
    end
  end

  // ---------------- stage 1: global/chooser/local history read ----------
  logic         s1_valid;
  logic         s1_taken;
  logic [G-1:0] s1_gi;
  logic [P-1:0] s1_pi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_taken <= in_taken;
      s1_gi    <= in_gi;
      s1_pi    <= in_pi;
    end
  end

  // record of the table writes made at the previous edge, for forwarding
  logic         wr_g_valid, wr_c_valid, wr_l_valid, wr_h_valid;
  logic [G-1:0] wr_gi;
  logic [1:0]   wr_gval, wr_cval, wr_lval;
  logic [L-1:0] wr_li;
  logic [P-1:0] wr_pi;
  logic [L-1:0] wr_hval;

  logic [1:0]   gctr_q, choose_q, lctr_q;
  logic [L-1:0] lhist_q;

  logic [L-1:0] lhist_cur;
  logic [L:0]   lhist_shift;
  logic [L-1:0] lhist_new;
  logic [L-1:0] s1_li;
  logic         h_we;
  logic [1:0]   gctr_s1, choose_s1;

  always_comb begin
    lhist_cur   = (wr_h_valid && (wr_pi == s1_pi)) ? wr_hval : lhist_q;
    lhist_shift = {lhist_cur, s1_taken};
    lhist_new   = lhist_shift[L-1:0];
    s1_li       = lhist_cur & lmask;
    h_we        = s1_valid && is_tour;
    gctr_s1     = (wr_g_valid && (wr_gi == s1_gi)) ? wr_gval : gctr_q;
    choose_s1   = (wr_c_valid && (wr_gi == s1_gi)) ? wr_cval : choose_q;
  end

  // ---------------- stage 2: predict and train ----------------
  logic         s2_valid;
  logic         s2_taken;
  logic [G-1:0] s2_gi;
  logic [L-1:0] s2_li;
  logic [1:0]   s2_gctr, s2_choose;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_taken  <= s1_taken;
      s2_gi     <= s1_gi;
      s2_li     <= s1_li;
      s2_gctr   <= gctr_s1;
      s2_choose <= choose_s1;
    end
  end

  logic [1:0] gctr_cur, choose_cur, lctr_cur;
  logic       gp, lp, pred;
  logic       g_we, c_we, l_we;
  logic [1:0] gval_new, cval_new, lval_new;

  always_comb begin
    gctr_cur   = (wr_g_valid && (wr_gi == s2_gi)) ? wr_gval : s2_gctr;
    choose_cur = (wr_c_valid && (wr_gi == s2_gi)) ? wr_cval : s2_choose;
    lctr_cur   = (wr_l_valid && (wr_li == s2_li)) ? wr_lval : lctr_q;
    gp = gctr_cur[1];
    lp = lctr_cur[1];
    gval_new = gtbp_pkg::ctr_step(gctr_cur, s2_taken);
    lval_new = gtbp_pkg::ctr_step(lctr_cur, s2_taken);
    // chooser moves only when exactly one side was right
    if (gp == s2_taken && lp != s2_taken) begin
      cval_new = gtbp_pkg::ctr_step(choose_cur, 1'b0);
    end else if (lp == s2_taken && gp != s2_taken) begin
      cval_new = gtbp_pkg::ctr_step(choose_cur, 1'b1);
    end else begin
      cval_new = choose_cur;
    end
    pred = 1'b0;
    g_we = 1'b0;
    c_we = 1'b0;
    l_we = 1'b0;
    unique case (predictor_mode)
      gtbp_pkg::MODE_STATIC_TAKEN: pred = 1'b1;
      gtbp_pkg::MODE_GSHARE: begin
        pred = gp;
        g_we = s2_valid;
      end
      gtbp_pkg::MODE_TOURNAMENT: begin
        pred = choose_cur[1] ? lp : gp;
        g_we = s2_valid;
        c_we = s2_valid;
        l_we = s2_valid;
      end
      gtbp_pkg::MODE_NOT_TAKEN: pred = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_g_valid <= 1'b0;
      wr_c_valid <= 1'b0;
      wr_l_valid <= 1'b0;
      wr_h_valid <= 1'b0;
    end else begin
      wr_g_valid <= g_we;
      wr_c_valid <= c_we;
      wr_l_valid <= l_we;
      wr_h_valid <= h_we;
    end
  end

  always_ff @(posedge clk) begin
    wr_gi   <= s2_gi;
    wr_gval <= gval_new;
    wr_cval <= cval_new;
    wr_li   <= s2_li;
    wr_lval <= lval_new;
    wr_pi   <= s1_pi;
    wr_hval <= lhist_new;
  end

  // ---------------- tables ----------------
  logic [1:0]   global_counters  [GDEPTH];
  logic [1:0]   chooser_counters [GDEPTH];
  logic [1:0]   local_counters   [LDEPTH];
  logic [L-1:0] local_histories  [PDEPTH];

  logic         gmem_we, cmem_we, lmem_we, hmem_we;
  logic [G-1:0] gmem_wa;
  logic [L-1:0] lmem_wa;
  logic [P-1:0] hmem_wa;
  logic [1:0]   gmem_wd, cmem_wd, lmem_wd;
  logic [L-1:0] hmem_wd;

  always_comb begin
    gmem_we = clearing ? clr_hit_g : g_we;
    cmem_we = clearing ? clr_hit_g : c_we;
    lmem_we = clearing ? clr_hit_l : l_we;
    hmem_we = clearing ? clr_hit_p : h_we;
    gmem_wa = clearing ? clr_addr[G-1:0] : s2_gi;
    lmem_wa = clearing ? clr_addr[L-1:0] : s2_li;
    hmem_wa = clearing ? clr_addr[P-1:0] : s1_pi;
    gmem_wd = clearing ? gtbp_pkg::CTR_WEAK_LOW : gval_new;
    cmem_wd = clearing ? gtbp_pkg::CTR_WEAK_LOW : cval_new;
    lmem_wd = clearing ? gtbp_pkg::CTR_WEAK_LOW : lval_new;
    hmem_wd = clearing ? '0 : lhist_new;
  end

  always_ff @(posedge clk) begin
    if (gmem_we) global_counters[gmem_wa] <= gmem_wd;
    if (in_accept) gctr_q <= global_counters[in_gi];
  end

  always_ff @(posedge clk) begin
    if (cmem_we) chooser_counters[gmem_wa] <= cmem_wd;
    if (in_accept) choose_q <= chooser_counters[in_gi];
  end

  always_ff @(posedge clk) begin
    if (hmem_we) local_histories[hmem_wa] <= hmem_wd;
    if (in_accept) lhist_q <= local_histories[in_pi];
  end

  always_ff @(posedge clk) begin
    if (lmem_we) local_counters[lmem_wa] <= lmem_wd;
    if (s1_valid) lctr_q <= local_counters[s1_li];
  end

  // ---------------- result queue ----------------
  logic [gtbp_pkg::OUT_DEPTH-1:0] out_bits;
  logic [OUT_AW-1:0] out_wptr, out_rptr;
  logic [OUT_AW:0]   out_count;
  logic [OUT_AW:0]   owned;
  logic              out_pop;

  assign out_pop = m_axis_tvalid && m_axis_tready;
  assign owned   = out_count + (OUT_AW+1)'(s1_valid) + (OUT_AW+1)'(s2_valid);

  assign s_axis_tready = clear_done && (owned < (OUT_AW+1)'(gtbp_pkg::OUT_DEPTH));
  assign m_axis_tvalid = (out_count != '0);
  assign m_axis_tdata  = {7'b0, out_bits[out_rptr]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wptr  <= '0;
      out_rptr  <= '0;
      out_count <= '0;
    end else begin
      if (s2_valid) out_wptr <= out_wptr + 1'b1;
      if (out_pop) out_rptr <= out_rptr + 1'b1;
      out_count <= out_count + (OUT_AW+1)'(s2_valid) - (OUT_AW+1)'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) out_bits[out_wptr] <= pred;
  end

  // ---------------- assertions ----------------
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    owned <= (OUT_AW+1)'(gtbp_pkg::OUT_DEPTH))
    else $error("more branches in flight than the result queue can hold");

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> clear_done)
    else $error("branch accepted during table clearing");

  a_stage_flow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> s2_valid)
    else $error("stage 1 item lost before stage 2");

  a_queue_push: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !out_pop |=> out_count == $past(out_count) + 1'b1)
    else $error("result not pushed into queue");

endmodule

### sim/tb_gshare_tournament_branch_predictor.sv
// Self-checking testbench for the gshare / tournament branch predictor.
`timescale 1ns / 100ps

module tb_gshare_tournament_branch_predictor;

  // widest history / index lengths the block is built with
  localparam int G_WIDEST = 13;
  localparam int L_WIDEST = 11;
  localparam int P_WIDEST = 10;
  // cycle budget for the clearing pass after reset plus 1524 branches at
  // worst-case gaps and stalls, with ample margin
  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [39:0] s_axis_tdata = '0;   // pc[31:0], outcome[32], zero pad [39:33]
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  m_axis_tdata;        // predicted_taken[0], zero pad [7:1]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;

  // both sides run without idling while this is set
  bit steady = 1'b0;
  int cycle_count = 0;
  int stall_left = 0;

  always #10 clk = ~clk;

  gshare_tournament_branch_predictor dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------
  // Scoreboard: a shadow copy of every predictor table. Each accepted
  // branch is run through it at once, which yields the prediction the
  // block must return and trains the shadow tables; the predictions
  // queue up in branch order until m_axis hands them back.
  // --------------------------------------------------------------------
  class prediction_board;
    gtbp_pkg::mode_t mode;
    logic [3:0]  ghist_len, lhist_len, pc_len;
    logic [12:0] ghist;              // newest outcome in bit 0
    logic [1:0]  gctr    [8192];
    logic [1:0]  chooser [8192];     // 0/1 pick global, 2/3 pick local
    logic [10:0] lhist   [1024];
    logic [1:0]  lctr    [2048];
    bit          predictions_due [$];
    int          mismatches, compared, settings;
    int          per_mode [4];

    function new();
      mode = gtbp_pkg::MODE_STATIC_TAKEN;
      ghist_len = gtbp_pkg::GLOBAL_BITS_RESET;
      lhist_len = gtbp_pkg::LOCAL_BITS_RESET;
      pc_len = gtbp_pkg::PC_BITS_RESET;
      ghist = '0;
      foreach (gctr[i]) begin
        gctr[i] = gtbp_pkg::CTR_WEAK_LOW;
        chooser[i] = gtbp_pkg::CTR_WEAK_LOW;
      end
      foreach (lhist[i]) lhist[i] = '0;
      foreach (lctr[i]) lctr[i] = gtbp_pkg::CTR_WEAK_LOW;
      mismatches = 0;
      compared = 0;
      settings = 0;
      foreach (per_mode[i]) per_mode[i] = 0;
    endfunction

    function void set_reg(gtbp_pkg::cfg_reg_t idx, logic [3:0] d);
      case (idx)
        gtbp_pkg::REG_MODE:        mode = gtbp_pkg::mode_t'(d[1:0]);
        gtbp_pkg::REG_GLOBAL_BITS: ghist_len = d;
        gtbp_pkg::REG_LOCAL_BITS:  lhist_len = d;
        gtbp_pkg::REG_PC_BITS:     pc_len = d;
        default: ;
      endcase
    endfunction

    // a length of zero counts as one; above the build width it is clipped
    static function int unsigned used_mask(logic [3:0] len, int unsigned widest);
      int unsigned n;
      n = (len == 4'd0) ? 1 : len;
      if (n > widest) n = widest;
      return (1 << n) - 1;
    endfunction

    static function logic [1:0] nudge(logic [1:0] c, logic up);
      if (up) return (c == 2'd3) ? c : c + 2'd1;
      return (c == 2'd0) ? c : c - 2'd1;
    endfunction

    function int pending();
      return predictions_due.size();
    endfunction

    function void note_branch(logic [31:0] pc, logic taken);
      int unsigned gi, pi, li;
      logic        gp, lp, guess;
      per_mode[int'(mode)]++;
      case (mode)
        gtbp_pkg::MODE_STATIC_TAKEN: guess = 1'b1;
        gtbp_pkg::MODE_GSHARE: begin
          gi = (pc ^ {19'd0, ghist}) & used_mask(ghist_len, G_WIDEST);
          guess = gctr[gi][1];
          gctr[gi] = nudge(gctr[gi], taken);
          ghist = {ghist[11:0], taken};
        end
        gtbp_pkg::MODE_TOURNAMENT: begin
          gi = ghist & used_mask(ghist_len, G_WIDEST);
          pi = pc & used_mask(pc_len, P_WIDEST);
          li = lhist[pi] & used_mask(lhist_len, L_WIDEST);
          gp = gctr[gi][1];
          lp = lctr[li][1];
          guess = chooser[gi][1] ? lp : gp;
          // chooser only moves when exactly one side was right
          if (gp == taken && lp != taken) chooser[gi] = nudge(chooser[gi], 1'b0);
          else if (lp == taken && gp != taken) chooser[gi] = nudge(chooser[gi], 1'b1);
          gctr[gi] = nudge(gctr[gi], taken);
          lctr[li] = nudge(lctr[li], taken);
          ghist = {ghist[11:0], taken};
          lhist[pi] = {lhist[pi][9:0], taken};
        end
        default: guess = 1'b0;
      endcase
      predictions_due.push_back(guess);
    endfunction

    function void check_prediction(logic actual);
      bit want;
      if (predictions_due.size() == 0) begin
        mismatches++;
        $display("%0t: predicted_taken expected none, actual %b", $time, actual);
        return;
      end
      want = predictions_due.pop_front();
      compared++;
      if (actual !== want) begin
        mismatches++;
        $display("%0t: predicted_taken expected %b, actual %b", $time, want, actual);
      end
    endfunction
  endclass

  prediction_board board;

  // idle length: mostly none or short, now and then long
  function automatic int idle_cycles();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // history/index length: zero, one, widest, over-range, or anything between
  function automatic logic [3:0] pick_len(int widest);
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'(widest);
      3: return 4'd15;
      default: return 4'($urandom_range(1, widest));
    endcase
  endfunction

  // training modes get most of the phases
  function automatic gtbp_pkg::mode_t pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return gtbp_pkg::MODE_STATIC_TAKEN;
    if (r == 1) return gtbp_pkg::MODE_NOT_TAKEN;
    if (r < 6) return gtbp_pkg::MODE_GSHARE;
    return gtbp_pkg::MODE_TOURNAMENT;
  endfunction

  // --------------------------------------------------------------------
  // Result side: random back-pressure, check on every m_axis transaction.
  // --------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_prediction(m_axis_tdata[0]);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left <= idle_cycles();
      m_axis_tready <= 1'b1;
    end
  end

  // one s_axis transaction, with a random idle gap in front of it
  task automatic send_branch(logic [31:0] pc, logic taken);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= {7'd0, taken, pc};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    board.note_branch(pc, taken);
  endtask

  // hold off the sender until every outstanding prediction is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic write_reg(gtbp_pkg::cfg_reg_t idx, logic [3:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, d);
  endtask

  // only called with the block idle
  task automatic apply_config(gtbp_pkg::mode_t m, logic [3:0] g, logic [3:0] l,
                              logic [3:0] p);
    write_reg(gtbp_pkg::REG_MODE, {2'b00, m});
    write_reg(gtbp_pkg::REG_GLOBAL_BITS, g);
    write_reg(gtbp_pkg::REG_LOCAL_BITS, l);
    write_reg(gtbp_pkg::REG_PC_BITS, p);
    cfg_valid <= 1'b0;
    board.settings++;
  endtask

  // Random phase: mostly a handful of branch sites each replaying a short
  // periodic pattern, so counters saturate and local history pays off;
  // the rest is random PCs with random outcomes.
  task automatic run_phase(int n_items);
    logic [31:0] site [4];
    logic [7:0]  pattern [4];
    int          span [4];
    int          step [4];
    int          k;
    logic [31:0] pc;
    logic        taken;
    for (k = 0; k < 4; k++) begin
      site[k] = $urandom;
      pattern[k] = 8'($urandom_range(0, 255));
      span[k] = $urandom_range(1, 8);
      step[k] = 0;
    end
    repeat (n_items) begin
      if ($urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, 3);
        pc = site[k];
        taken = pattern[k][step[k]];
        step[k] = (step[k] + 1) % span[k];
      end else begin
        pc = $urandom;
        taken = 1'($urandom_range(0, 1));
      end
      send_branch(pc, taken);
      if ($urandom_range(0, 199) == 0) drain();
    end
    drain();
  endtask

  initial begin
    int i;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: static taken, tables must stay untouched
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    drain();
    // always not taken, also no training
    apply_config(gtbp_pkg::MODE_NOT_TAKEN, gtbp_pkg::GLOBAL_BITS_RESET,
                 gtbp_pkg::LOCAL_BITS_RESET, gtbp_pkg::PC_BITS_RESET);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h0000_0000, 1'b0);
    drain();
    // gshare with zero lengths (treated as one bit)
    apply_config(gtbp_pkg::MODE_GSHARE, 4'd0, 4'd0, 4'd0);
    repeat (2) begin
      send_branch(32'h0000_0001, 1'b1);
      send_branch(32'hFFFF_FFFE, 1'b1);
    end
    drain();
    // gshare with over-range lengths (clipped to build widths)
    apply_config(gtbp_pkg::MODE_GSHARE, 4'd15, 4'd15, 4'd15);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h8000_1FFF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    drain();
    // tournament on tables gshare already trained; alternating branch
    // favours the local side
    apply_config(gtbp_pkg::MODE_TOURNAMENT, gtbp_pkg::GLOBAL_BITS_RESET,
                 gtbp_pkg::LOCAL_BITS_RESET, gtbp_pkg::PC_BITS_RESET);
    for (i = 0; i < 8; i++) send_branch(32'h0000_03FF, 1'(i));
    drain();
    // tournament, shortest global and PC index, over-range local history
    apply_config(gtbp_pkg::MODE_TOURNAMENT, 4'd0, 4'd15, 4'd0);
    send_branch(32'h8000_0000, 1'b1);
    send_branch(32'h7FFF_FFFF, 1'b0);
    send_branch(32'h8000_0000, 1'b1);
    send_branch(32'h7FFF_FFFF, 1'b1);
    drain();

    // random phases, a few of them without any idling
    for (i = 0; i < 12; i++) begin
      steady = (i % 4 == 1);
      apply_config(pick_mode(), pick_len(G_WIDEST), pick_len(L_WIDEST), pick_len(P_WIDEST));
      run_phase(125);
    end
    steady = 1'b0;

    // let the pipeline settle; leave room for anything stray to show up
    repeat (12) @(posedge clk);
    $display("Ran %0d branches: static %0d, gshare %0d, tournament %0d, not taken %0d",
             board.per_mode[0] + board.per_mode[1] + board.per_mode[2] + board.per_mode[3],
             board.per_mode[0], board.per_mode[1], board.per_mode[2], board.per_mode[3]);
    $display("%0d register settings applied, %0d predictions compared, %0d wrong",
             board.settings, board.compared, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Mismatches found");
    $finish;
  end

endmodule
